### design/packet_sequence_slice_inventory_assert.svh
`ifndef PACKET_SEQUENCE_SLICE_INVENTORY_ASSERT_SVH
`define PACKET_SEQUENCE_SLICE_INVENTORY_ASSERT_SVH

// same-cycle implication, checked on clk and muted in reset
`define PSINV_CHECK_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on clk and muted in reset
`define PSINV_CHECK_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/psinv_pkg.sv
package psinv_pkg;

  localparam int COUNT_BITS  = 14;
  localparam int POS_BITS    = 48;
  localparam int APID_BITS   = 11;
  localparam int SIZE_BITS   = COUNT_BITS + 1;
  localparam int DAY_BITS    = 16;
  localparam int MSEC_BITS   = 32;
  localparam int SAT_BITS    = 32;
  localparam int DATA_BITS   = 32;
  localparam int ADDR_BITS   = 3;

  // serial position subtract, one digit per cycle
  localparam int DIGIT_BITS   = 4;
  localparam int POS_DIGITS   = POS_BITS / DIGIT_BITS;
  localparam int DIG_CNT_BITS = $clog2(POS_DIGITS + 1);

  // remainder loop, one dividend bit per cycle
  localparam int STEP_BITS = $clog2(COUNT_BITS);

  localparam logic [APID_BITS-1:0] APID_RESET = APID_BITS'(64);
  localparam logic [SIZE_BITS-1:0] SIZE_RESET = SIZE_BITS'(4096);

  // register select is paddr bit 2
  localparam logic REG_APID = 1'b0;
  localparam logic REG_SIZE = 1'b1;

  typedef struct packed {
    logic [MSEC_BITS-1:0]  stamp_msec;
    logic [DAY_BITS-1:0]   stamp_day;
    logic [POS_BITS-1:0]   byte_pos;
    logic [COUNT_BITS-1:0] seq_count;
    logic [APID_BITS-1:0]  apid;
  } in_item_t;

  typedef struct packed {
    logic [SAT_BITS-1:0]   total_gaps;
    logic [SAT_BITS-1:0]   gap_count;
    logic [SAT_BITS-1:0]   packet_count;
    logic [MSEC_BITS-1:0]  start_msec;
    logic [DAY_BITS-1:0]   start_day;
    logic [POS_BITS-1:0]   slice_bytes;
    logic [POS_BITS-1:0]   start_position;
    logic [COUNT_BITS-1:0] slice_base_count;
    logic [SAT_BITS-1:0]   slice_number;
  } out_item_t;

  localparam int IN_USED  = $bits(in_item_t);
  localparam int OUT_USED = $bits(out_item_t);
  localparam int IN_BITS  = ((IN_USED + 7) / 8) * 8;
  localparam int OUT_BITS = ((OUT_USED + 7) / 8) * 8;
  localparam int IN_PAD   = IN_BITS - IN_USED;
  localparam int OUT_PAD  = OUT_BITS - OUT_USED;

  typedef struct packed {
    logic busy;
    logic done;
  } rem_status_t;

endpackage

### design/psinv_rem.sv
// restoring remainder, one dividend bit per cycle, msb first
module psinv_rem (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [psinv_pkg::COUNT_BITS-1:0]   dividend,
  input  logic [psinv_pkg::SIZE_BITS-1:0]    divisor,
  output psinv_pkg::rem_status_t             status,
  output logic [psinv_pkg::COUNT_BITS-1:0]   remainder
);

  localparam logic [psinv_pkg::STEP_BITS-1:0] LAST_STEP =
    psinv_pkg::STEP_BITS'(psinv_pkg::COUNT_BITS - 1);

  logic [psinv_pkg::COUNT_BITS-1:0] quo_sh;
  logic [psinv_pkg::SIZE_BITS-1:0]  rem;
  logic [psinv_pkg::SIZE_BITS-1:0]  div_r;
  logic [psinv_pkg::SIZE_BITS-1:0]  rem_next;
  logic [psinv_pkg::SIZE_BITS:0]    trial;
  logic [psinv_pkg::SIZE_BITS:0]    diff;
  logic [psinv_pkg::STEP_BITS-1:0]  step;
  logic                             busy;
  logic                             done;

  always_comb begin
    trial = {rem, quo_sh[psinv_pkg::COUNT_BITS-1]};
    diff  = trial - {1'b0, div_r};
    // top bit set means the trial went below zero
    rem_next = diff[psinv_pkg::SIZE_BITS] ? trial[psinv_pkg::SIZE_BITS-1:0]
                                          : diff[psinv_pkg::SIZE_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + psinv_pkg::STEP_BITS'(1);
        if (step == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_sh <= dividend;
      rem    <= '0;
      div_r  <= divisor;
    end else if (busy) begin
      quo_sh <= quo_sh << 1;
      rem    <= rem_next;
    end
  end

  assign status    = '{busy: busy, done: done};
  // remainder never exceeds the dividend
  assign remainder = rem[psinv_pkg::COUNT_BITS-1:0];

endmodule

### design/packet_sequence_slice_inventory.sv
// Packet sequence slice inventory: each input item is one packet header (apid,
// 14-bit sequence count, stream byte position, day/msec stamp). Items of other
// apids are taken and dropped. A reference item is loaded, the bit-serial
// remainder loop then finds the slice base (the count rounded down to a
// multiple of the slice size), the result is picked up and a commit state
// writes the inventory, holding there if a report cannot yet be loaded,
// before the block is ready again. The byte size of the slice is built by a
// 4-bit digit-serial subtractor that runs in the shadow of the remainder
// loop. Gaps are the modular count difference minus one and saturate at
// 2^32-1, as do the packet and slice counters. When a packet opens a new
// slice after an earlier one, one item reports the old slice; it sits in an
// output register, and the block goes on with the next packet while it waits,
// holding only when a second report is due before the first was taken.
// Registers: 0x0 reference apid (reset 64), 0x4 slice size (reset 4096, zero
// acts as one).
module packet_sequence_slice_inventory (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // apid, seq_count, byte_pos, stamp_day, stamp_msec, zero pad
  input  logic [psinv_pkg::IN_BITS-1:0]      s_tdata,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // slice_number, slice_base_count, start_position, slice_bytes, start_day,
  // start_msec, packet_count, gap_count, total_gaps, zero pad
  output logic [psinv_pkg::OUT_BITS-1:0]     m_tdata,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [psinv_pkg::ADDR_BITS-1:0]    paddr,
  input  logic [psinv_pkg::DATA_BITS-1:0]    pwdata,
  output logic [psinv_pkg::DATA_BITS-1:0]    prdata,
  output logic                               pready
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_COMMIT
  } state_t;

  function automatic logic [psinv_pkg::SAT_BITS-1:0] sat_add(
    input logic [psinv_pkg::SAT_BITS-1:0]   a,
    input logic [psinv_pkg::COUNT_BITS-1:0] b
  );
    logic [psinv_pkg::SAT_BITS:0] s;
    s = {1'b0, a} + (psinv_pkg::SAT_BITS + 1)'(b);
    return s[psinv_pkg::SAT_BITS] ? '1 : s[psinv_pkg::SAT_BITS-1:0];
  endfunction

  function automatic logic [psinv_pkg::SAT_BITS-1:0] sat_inc(
    input logic [psinv_pkg::SAT_BITS-1:0] a
  );
    return (a == '1) ? a : a + psinv_pkg::SAT_BITS'(1);
  endfunction

  state_t state;

  // configuration
  logic [psinv_pkg::APID_BITS-1:0]  reference_apid;
  logic [psinv_pkg::SIZE_BITS-1:0]  packets_per_slice;
  logic                             cfg_write;

  // inventory state
  logic                             any_seen;
  logic [psinv_pkg::COUNT_BITS-1:0] last_count;
  logic                             slice_open;
  logic [psinv_pkg::COUNT_BITS-1:0] current_base;
  logic [psinv_pkg::SAT_BITS-1:0]   slices_started;
  logic [psinv_pkg::SAT_BITS-1:0]   slice_packets;
  logic [psinv_pkg::SAT_BITS-1:0]   slice_gaps;
  logic [psinv_pkg::SAT_BITS-1:0]   stream_gaps;
  logic [psinv_pkg::POS_BITS-1:0]   slice_first_pos;
  logic [psinv_pkg::DAY_BITS-1:0]   slice_start_day;
  logic [psinv_pkg::MSEC_BITS-1:0]  slice_start_msec;

  // item being worked on
  psinv_pkg::in_item_t              in_item;
  logic                             ref_hit;
  logic [psinv_pkg::COUNT_BITS-1:0] seq_diff;
  logic [psinv_pkg::COUNT_BITS-1:0] gap_in;
  logic [psinv_pkg::SIZE_BITS-1:0]  size_eff;
  logic [psinv_pkg::COUNT_BITS-1:0] cnt_r;
  logic [psinv_pkg::COUNT_BITS-1:0] gap_add;
  logic [psinv_pkg::DAY_BITS-1:0]   day_r;
  logic [psinv_pkg::MSEC_BITS-1:0]  msec_r;

  // digit-serial byte size
  logic [psinv_pkg::POS_BITS-1:0]     pos_sh;
  logic [psinv_pkg::POS_BITS-1:0]     start_sh;
  logic [psinv_pkg::POS_BITS-1:0]     diff_sh;
  logic [psinv_pkg::DIGIT_BITS:0]     dsum;
  logic                               carry;
  logic [psinv_pkg::DIG_CNT_BITS-1:0] dig;
  logic                               dig_done;

  // slice base and commit
  psinv_pkg::rem_status_t           rem_st;
  logic [psinv_pkg::COUNT_BITS-1:0] rem_val;
  logic                             rem_fin;
  logic [psinv_pkg::COUNT_BITS-1:0] base;
  logic                             new_slice;
  logic                             report;
  logic                             stall;
  logic                             commit;
  logic [psinv_pkg::SAT_BITS-1:0]   sg_sum;
  logic [psinv_pkg::SAT_BITS-1:0]   tg_sum;
  psinv_pkg::out_item_t             out_reg;

  assign in_item  = psinv_pkg::in_item_t'(s_tdata[psinv_pkg::IN_USED-1:0]);
  assign s_tready = (state == ST_IDLE);
  assign ref_hit  = s_tvalid && s_tready && (in_item.apid == reference_apid);
  assign m_tdata  = {{psinv_pkg::OUT_PAD{1'b0}}, out_reg};

  // apb side, no wait states
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      psinv_pkg::REG_APID: prdata = psinv_pkg::DATA_BITS'(reference_apid);
      psinv_pkg::REG_SIZE: prdata = psinv_pkg::DATA_BITS'(packets_per_slice);
      default:             prdata = '0;
    endcase
  end

  // gaps ahead of this packet, none on the first one or on a repeat
  always_comb begin
    seq_diff = in_item.seq_count - last_count;
    gap_in   = (any_seen && seq_diff >= psinv_pkg::COUNT_BITS'(2))
               ? seq_diff - psinv_pkg::COUNT_BITS'(1) : '0;
    size_eff = (packets_per_slice == '0) ? psinv_pkg::SIZE_BITS'(1)
                                         : packets_per_slice;
  end

  psinv_rem u_rem (
    .clk       (clk),
    .rst       (rst),
    .start     (ref_hit),
    .dividend  (in_item.seq_count),
    .divisor   (size_eff),
    .status    (rem_st),
    .remainder (rem_val)
  );

  // low digit of pos minus start, borrow carried between cycles
  assign dsum = {1'b0, pos_sh[psinv_pkg::DIGIT_BITS-1:0]}
              + {1'b0, ~start_sh[psinv_pkg::DIGIT_BITS-1:0]}
              + {{psinv_pkg::DIGIT_BITS{1'b0}}, carry};
  assign dig_done = (dig == psinv_pkg::DIG_CNT_BITS'(psinv_pkg::POS_DIGITS));

  always_comb begin
    base      = cnt_r - rem_val;
    new_slice = !slice_open || (base != current_base);
    report    = new_slice && slice_open;
    stall     = report && m_tvalid && !m_tready;
    commit    = (state == ST_COMMIT) && !stall;
    sg_sum    = sat_add(slice_gaps, gap_add);
    tg_sum    = sat_add(stream_gaps, gap_add);
  end

  // control and inventory state
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      m_tvalid          <= 1'b0;
      rem_fin           <= 1'b0;
      dig               <= '0;
      carry             <= 1'b1;
      reference_apid    <= psinv_pkg::APID_RESET;
      packets_per_slice <= psinv_pkg::SIZE_RESET;
      any_seen          <= 1'b0;
      last_count        <= '0;
      slice_open        <= 1'b0;
      current_base      <= '0;
      slices_started    <= '0;
      slice_packets     <= '0;
      slice_gaps        <= '0;
      stream_gaps       <= '0;
      slice_first_pos   <= '0;
      slice_start_day   <= '0;
      slice_start_msec  <= '0;
    end else begin
      // a report loaded in the same cycle keeps valid high
      if (m_tvalid && m_tready && !(commit && report)) begin
        m_tvalid <= 1'b0;
      end
      if (cfg_write) begin
        unique case (paddr[2])
          psinv_pkg::REG_APID: reference_apid <= pwdata[psinv_pkg::APID_BITS-1:0];
          psinv_pkg::REG_SIZE: packets_per_slice <= pwdata[psinv_pkg::SIZE_BITS-1:0];
          default: ;
        endcase
      end
      unique case (state)
        ST_IDLE: begin
          if (ref_hit) begin
            any_seen   <= 1'b1;
            last_count <= in_item.seq_count;
            dig        <= '0;
            carry      <= 1'b1;
            rem_fin    <= 1'b0;
            state      <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (!dig_done) begin
            dig   <= dig + psinv_pkg::DIG_CNT_BITS'(1);
            carry <= dsum[psinv_pkg::DIGIT_BITS];
          end
          if (rem_st.done) begin
            rem_fin <= 1'b1;
          end
          if ((rem_st.done || rem_fin) && dig_done) begin
            state <= ST_COMMIT;
          end
        end
        ST_COMMIT: begin
          if (!stall) begin
            stream_gaps <= tg_sum;
            if (report) begin
              m_tvalid <= 1'b1;
            end
            if (new_slice) begin
              // new slice opens with count minus base as its gaps
              slices_started   <= sat_inc(slices_started);
              slice_open       <= 1'b1;
              current_base     <= base;
              slice_gaps       <= psinv_pkg::SAT_BITS'(rem_val);
              slice_packets    <= psinv_pkg::SAT_BITS'(1);
              slice_first_pos  <= pos_sh;
              slice_start_day  <= day_r;
              slice_start_msec <= msec_r;
            end else begin
              slice_gaps    <= sg_sum;
              slice_packets <= sat_inc(slice_packets);
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // item payload, serial shifters and report register
  always_ff @(posedge clk) begin
    if (ref_hit) begin
      cnt_r    <= in_item.seq_count;
      gap_add  <= gap_in;
      pos_sh   <= in_item.byte_pos;
      start_sh <= slice_first_pos;
      day_r    <= in_item.stamp_day;
      msec_r   <= in_item.stamp_msec;
    end else if (state == ST_RUN && !dig_done) begin
      // pos rotates so it is whole again after the last digit
      pos_sh   <= {pos_sh[psinv_pkg::DIGIT_BITS-1:0],
                   pos_sh[psinv_pkg::POS_BITS-1:psinv_pkg::DIGIT_BITS]};
      start_sh <= start_sh >> psinv_pkg::DIGIT_BITS;
      diff_sh  <= {dsum[psinv_pkg::DIGIT_BITS-1:0],
                   diff_sh[psinv_pkg::POS_BITS-1:psinv_pkg::DIGIT_BITS]};
    end
    if (commit && report) begin
      out_reg.slice_number     <= slices_started - psinv_pkg::SAT_BITS'(1);
      out_reg.slice_base_count <= current_base;
      out_reg.start_position   <= slice_first_pos;
      out_reg.slice_bytes      <= diff_sh;
      out_reg.start_day        <= slice_start_day;
      out_reg.start_msec       <= slice_start_msec;
      out_reg.packet_count     <= slice_packets;
      out_reg.gap_count        <= sg_sum;
      out_reg.total_gaps       <= tg_sum;
    end
  end

`include "packet_sequence_slice_inventory_assert.svh"

  // an open slice always has been counted
  `PSINV_CHECK_NOW(a_open_counted, slice_open, slices_started != '0, "open slice uncounted")
  // the remainder only finishes while an item is being worked on
  `PSINV_CHECK_NOW(a_rem_in_run, rem_st.done, state == ST_RUN, "remainder done outside run")
  // no new item while the remainder loop still runs
  `PSINV_CHECK_NOW(a_idle_rem_quiet, s_tready, !rem_st.busy, "ready while remainder busy")
  // a finished commit always returns to accepting items
  `PSINV_CHECK_NEXT(a_commit_frees, commit, s_tready, "not ready after commit")

endmodule

### test/packet_sequence_slice_inventory_test.sv
module packet_sequence_slice_inventory_test;
  timeunit 1ns;
  timeprecision 1ps;

  // generous bound for the whole run of header items
  localparam int unsigned CYCLE_LIMIT = 400000;
  // receiver hold-off for the backpressure test, in cycles
  localparam int unsigned LONG_HOLD = 400;
  // cycles allowed for an item still in flight that reports nothing
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned RANDOM_PACKETS = 1000;
  localparam int unsigned PRINT_LIMIT = 40;

  // register addresses: paddr bit 2 selects the register
  localparam logic [psinv_pkg::ADDR_BITS-1:0] APID_ADDR = {psinv_pkg::REG_APID, 2'b00};
  localparam logic [psinv_pkg::ADDR_BITS-1:0] SIZE_ADDR = {psinv_pkg::REG_SIZE, 2'b00};

  localparam logic [psinv_pkg::POS_BITS-1:0] POS_MAX = '1;

  // clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  // packet header stream in
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  // apid, seq_count, byte_pos, stamp_day, stamp_msec, zero pad
  logic [psinv_pkg::IN_BITS-1:0]  s_tdata = '0;

  // slice report stream out
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  // slice_number, slice_base_count, start_position, slice_bytes, start_day,
  // start_msec, packet_count, gap_count, total_gaps, zero pad
  logic [psinv_pkg::OUT_BITS-1:0] m_tdata;

  // register port
  logic                            psel = 1'b0;
  logic                            penable = 1'b0;
  logic                            pwrite = 1'b0;
  logic [psinv_pkg::ADDR_BITS-1:0] paddr = '0;
  logic [psinv_pkg::DATA_BITS-1:0] pwdata = '0;
  logic [psinv_pkg::DATA_BITS-1:0] prdata;
  logic                            pready;

  // predictor copy of the registers
  logic [psinv_pkg::APID_BITS-1:0] cfg_apid = psinv_pkg::APID_RESET;
  logic [psinv_pkg::SIZE_BITS-1:0] cfg_slice_size = psinv_pkg::SIZE_RESET;

  // predictor copy of the inventory state
  logic                             seen_any = 1'b0;
  logic [psinv_pkg::COUNT_BITS-1:0] prev_count = '0;
  logic                             slice_active = 1'b0;
  logic [psinv_pkg::COUNT_BITS-1:0] open_base = '0;
  logic [psinv_pkg::SAT_BITS-1:0]   slices_opened = '0;
  logic [psinv_pkg::SAT_BITS-1:0]   slice_pkts = '0;
  logic [psinv_pkg::SAT_BITS-1:0]   gaps_in_slice = '0;
  logic [psinv_pkg::SAT_BITS-1:0]   gaps_total = '0;
  logic [psinv_pkg::POS_BITS-1:0]   first_pos = '0;
  logic [psinv_pkg::DAY_BITS-1:0]   first_day = '0;
  logic [psinv_pkg::MSEC_BITS-1:0]  first_msec = '0;

  // slice reports still owed by the block, oldest first
  psinv_pkg::out_item_t slice_reports[$];

  int unsigned error_count = 0;
  int unsigned ref_packets_sent = 0;
  int unsigned cycle_count = 0;

  // shared with the sink: no idling on either side, long hold-off request
  bit steady_flow = 1'b0;
  bit hold_requested = 1'b0;

  packet_sequence_slice_inventory u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #5 clk = ~clk;

  // run bound
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic flag_error(input string msg);
    error_count++;
    if (error_count <= PRINT_LIMIT) begin
      $display("%0t: mismatch: %s", $time, msg);
    end
  endtask

  function automatic logic [psinv_pkg::SAT_BITS-1:0] add_capped(
    input logic [psinv_pkg::SAT_BITS-1:0] a,
    input logic [psinv_pkg::SAT_BITS-1:0] b
  );
    logic [psinv_pkg::SAT_BITS:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[psinv_pkg::SAT_BITS] ? '1 : sum[psinv_pkg::SAT_BITS-1:0];
  endfunction

  // inventory update for one accepted header; queues the report it causes
  task automatic account_packet(input psinv_pkg::in_item_t pkt);
    logic [psinv_pkg::COUNT_BITS-1:0] step;
    int unsigned                      span;
    int unsigned                      base;
    psinv_pkg::out_item_t             rep;
    if (pkt.apid != cfg_apid) return;
    // modular count difference, first packet counts no gap
    if (seen_any) begin
      step = pkt.seq_count - prev_count;
      if (step >= 2) begin
        gaps_in_slice = add_capped(gaps_in_slice, psinv_pkg::SAT_BITS'(step - 1'b1));
        gaps_total = add_capped(gaps_total, psinv_pkg::SAT_BITS'(step - 1'b1));
      end
    end
    seen_any = 1'b1;
    prev_count = pkt.seq_count;
    // zero slice size behaves as one
    span = (cfg_slice_size == 0) ? 1 : cfg_slice_size;
    base = (pkt.seq_count / span) * span;
    if (!slice_active || psinv_pkg::COUNT_BITS'(base) != open_base) begin
      if (slice_active) begin
        rep.slice_number     = slices_opened - 1'b1;
        rep.slice_base_count = open_base;
        rep.start_position   = first_pos;
        rep.slice_bytes      = pkt.byte_pos - first_pos;
        rep.start_day        = first_day;
        rep.start_msec       = first_msec;
        rep.packet_count     = slice_pkts;
        rep.gap_count        = gaps_in_slice;
        rep.total_gaps       = gaps_total;
        slice_reports.push_back(rep);
      end
      slices_opened = add_capped(slices_opened, 1);
      slice_active = 1'b1;
      open_base = psinv_pkg::COUNT_BITS'(base);
      gaps_in_slice = psinv_pkg::SAT_BITS'(pkt.seq_count - psinv_pkg::COUNT_BITS'(base));
      slice_pkts = '0;
      first_pos = pkt.byte_pos;
      first_day = pkt.stamp_day;
      first_msec = pkt.stamp_msec;
    end
    slice_pkts = add_capped(slice_pkts, 1);
  endtask

  task automatic compare_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
    if (got !== want) begin
      flag_error($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
    end
  endtask

  task automatic check_slice_report(input logic [psinv_pkg::OUT_BITS-1:0] word);
    psinv_pkg::out_item_t got;
    psinv_pkg::out_item_t want;
    got = word[psinv_pkg::OUT_USED-1:0];
    if (word[psinv_pkg::OUT_BITS-1:psinv_pkg::OUT_USED] !== '0) begin
      flag_error("report pad bits not zero");
    end
    if (slice_reports.size() == 0) begin
      flag_error($sformatf("unexpected report for slice base %0d", got.slice_base_count));
      return;
    end
    want = slice_reports.pop_front();
    compare_field("slice_number", got.slice_number, want.slice_number);
    compare_field("slice_base_count", got.slice_base_count, want.slice_base_count);
    compare_field("start_position", got.start_position, want.start_position);
    compare_field("slice_bytes", got.slice_bytes, want.slice_bytes);
    compare_field("start_day", got.start_day, want.start_day);
    compare_field("start_msec", got.start_msec, want.start_msec);
    compare_field("packet_count", got.packet_count, want.packet_count);
    compare_field("gap_count", got.gap_count, want.gap_count);
    compare_field("total_gaps", got.total_gaps, want.total_gaps);
  endtask

  // both streams sampled at the edge; results checked before new headers are
  // predicted so a stray result can never match its own cycle's prediction
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      check_slice_report(m_tdata);
    end
    if (!rst && s_tvalid && s_tready) begin
      account_packet(s_tdata[psinv_pkg::IN_USED-1:0]);
    end
  end

  // report sink: random stalls, a long hold-off on request
  initial begin : sink
    forever begin
      @(posedge clk);
      if (hold_requested) begin
        hold_requested = 1'b0;
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      m_tready <= steady_flow || ($urandom_range(99) >= 33);
    end
  end

  // one header item, with random idle cycles ahead of it
  task automatic send_packet(input logic [psinv_pkg::APID_BITS-1:0] apid,
                             input logic [psinv_pkg::COUNT_BITS-1:0] count,
                             input logic [psinv_pkg::POS_BITS-1:0] pos,
                             input logic [psinv_pkg::DAY_BITS-1:0] day,
                             input logic [psinv_pkg::MSEC_BITS-1:0] msec);
    psinv_pkg::in_item_t pkt;
    pkt.apid = apid;
    pkt.seq_count = count;
    pkt.byte_pos = pos;
    pkt.stamp_day = day;
    pkt.stamp_msec = msec;
    while (!steady_flow && $urandom_range(99) < 33) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {{psinv_pkg::IN_PAD{1'b0}}, pkt};
    do @(posedge clk); while (!s_tready);
    if (apid == cfg_apid) ref_packets_sent++;
  endtask

  // stop offering, wait for every owed report, then let the block go quiet
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (slice_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // one setup and one access phase, then the bus goes quiet
  task automatic apb_cycle(input bit is_write,
                           input logic [psinv_pkg::ADDR_BITS-1:0] addr,
                           input logic [psinv_pkg::DATA_BITS-1:0] wdata,
                           output logic [psinv_pkg::DATA_BITS-1:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= is_write;
    paddr <= addr;
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_register(input logic [psinv_pkg::ADDR_BITS-1:0] addr,
                                input logic [psinv_pkg::DATA_BITS-1:0] want);
    logic [psinv_pkg::DATA_BITS-1:0] got;
    apb_cycle(1'b0, addr, '0, got);
    if (got !== want) begin
      flag_error($sformatf("register 0x%0h reads 0x%0h want 0x%0h", addr, got, want));
    end
  endtask

  task automatic write_register(input logic [psinv_pkg::ADDR_BITS-1:0] addr,
                                input logic [psinv_pkg::DATA_BITS-1:0] value);
    logic [psinv_pkg::DATA_BITS-1:0] unused;
    apb_cycle(1'b1, addr, value, unused);
    if (addr == APID_ADDR) begin
      cfg_apid = value[psinv_pkg::APID_BITS-1:0];
      check_register(addr, psinv_pkg::DATA_BITS'(cfg_apid));
    end else begin
      cfg_slice_size = value[psinv_pkg::SIZE_BITS-1:0];
      check_register(addr, psinv_pkg::DATA_BITS'(cfg_slice_size));
    end
  endtask

  // mostly well-formed counter runs with random content, some noise and jumps
  task automatic send_random_run(input int unsigned n);
    logic [psinv_pkg::COUNT_BITS-1:0] count;
    logic [psinv_pkg::POS_BITS-1:0]   pos;
    logic [psinv_pkg::DAY_BITS-1:0]   day;
    logic [psinv_pkg::MSEC_BITS-1:0]  msec;
    int unsigned                      pick;
    count = psinv_pkg::COUNT_BITS'($urandom);
    pos = psinv_pkg::POS_BITS'({$urandom, $urandom});
    day = psinv_pkg::DAY_BITS'($urandom);
    msec = $urandom;
    for (int unsigned i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 12) begin
        // other apids, any content
        send_packet(psinv_pkg::APID_BITS'($urandom), psinv_pkg::COUNT_BITS'($urandom),
                    psinv_pkg::POS_BITS'({$urandom, $urandom}),
                    psinv_pkg::DAY_BITS'($urandom), $urandom);
      end else begin
        if (pick < 17) begin
          count = psinv_pkg::COUNT_BITS'($urandom);                 // broken sequence
        end else if (pick < 22) begin
          // repeated count
        end else if (pick < 30) begin
          count = count + psinv_pkg::COUNT_BITS'($urandom_range(2, 20)); // short gap
        end else begin
          count = count + 1'b1;
        end
        pos = pos + psinv_pkg::POS_BITS'($urandom_range(7, 65542));
        msec = msec + $urandom_range(0, 2000);
        if ($urandom_range(49) == 0) day = day + 1'b1;
        send_packet(cfg_apid, count, pos, day, msec);
      end
    end
  endtask

  task automatic test_reset_values();
    check_register(APID_ADDR, psinv_pkg::DATA_BITS'(psinv_pkg::APID_RESET));
    check_register(SIZE_ADDR, psinv_pkg::DATA_BITS'(psinv_pkg::SIZE_RESET));
  endtask

  // hand-picked headers under the reset settings
  task automatic test_directed_packets();
    send_packet('0, 14'd5, 48'd10, 16'd1, 32'd1);         // apid zero, ignored
    send_packet('1, 14'd6, 48'd20, 16'd2, 32'd2);         // top apid, ignored
    send_packet(psinv_pkg::APID_RESET, 14'd0, '0, '0, '0);       // first packet, no gap
    send_packet(psinv_pkg::APID_RESET, 14'd0, POS_MAX, '1, '1);  // repeated count
    send_packet(psinv_pkg::APID_RESET, 14'd1, 48'd100, 16'd3, 32'd30);
    send_packet(psinv_pkg::APID_RESET, 14'd5, 48'd300, 16'd3, 32'd40);      // three missing
    send_packet(psinv_pkg::APID_RESET, 14'd4095, 48'd1000, 16'd3, 32'd50);  // last of slice
    send_packet(psinv_pkg::APID_RESET, 14'd4096, 48'd2000, 16'd4, 32'd60);  // opens slice
    send_packet(psinv_pkg::APID_RESET, 14'd4100, 48'd2500, 16'd4, 32'd70);
    send_packet(psinv_pkg::APID_RESET, 14'd16383, 48'hFFFF_FFFF_FF00, 16'd5, 32'd80);
    send_packet(psinv_pkg::APID_RESET, 14'd0, 48'd16, 16'd6, 32'd90);       // count wraps
    send_packet(psinv_pkg::APID_RESET, 14'd8192, 48'h8000_0000_0000, 16'hFFFF,
                32'hFFFF_FFFF);
    send_packet(psinv_pkg::APID_RESET, 14'd8192, 48'h8000_0000_0001, 16'd0, 32'd0);
    send_packet(psinv_pkg::APID_RESET, 14'd12287, 48'h7FFF_FFFF_FFFF, 16'd7, 32'd100);
    send_packet(psinv_pkg::APID_RESET, 14'd12288, 48'h0000_0000_0100, 16'd8, 32'd110);
    settle();
  endtask

  // extreme register values, including masking of wide writes
  task automatic test_register_extremes();
    write_register(APID_ADDR, 32'hFFFF_FFFF);
    write_register(SIZE_ADDR, 32'hFFFF_FFFF);
    send_random_run(25);
    settle();
    write_register(APID_ADDR, 32'd0);                    // apid zero counts
    write_register(SIZE_ADDR, 32'd0);                    // acts as one
    send_random_run(30);
    settle();
    write_register(APID_ADDR, 32'd1);
    write_register(SIZE_ADDR, 32'd16384);                // one slice only
    send_random_run(25);
    settle();
    write_register(APID_ADDR, 32'd2047);
    write_register(SIZE_ADDR, 32'd1);
    send_random_run(30);
    settle();
    write_register(SIZE_ADDR, 32'd3);                    // does not divide 2^14
    send_random_run(30);
    settle();
  endtask

  // sink holds off while headers keep coming, every change of count opens a slice
  task automatic test_output_backpressure();
    write_register(APID_ADDR, 32'd100);
    write_register(SIZE_ADDR, 32'd1);
    steady_flow = 1'b1;
    hold_requested = 1'b1;
    send_random_run(40);
    settle();
    steady_flow = 1'b0;
  endtask

  task automatic test_random_streams();
    int unsigned                     first_sent;
    int unsigned                     phase;
    logic [psinv_pkg::DATA_BITS-1:0] size_word;
    first_sent = ref_packets_sent;
    phase = 0;
    while (ref_packets_sent - first_sent < RANDOM_PACKETS) begin
      if ($urandom_range(7) == 0) begin
        write_register(APID_ADDR, $urandom);
      end else begin
        write_register(APID_ADDR, $urandom_range(1, 2047));
      end
      case ($urandom_range(5))
        0: size_word = $urandom_range(1, 4);
        1: size_word = $urandom_range(5, 64);
        2: size_word = $urandom_range(65, 1024);
        3: size_word = 4096;
        4: size_word = $urandom_range(1, 16384);
        default: size_word = $urandom;
      endcase
      write_register(SIZE_ADDR, size_word);
      // every fourth phase runs with no idling at all
      steady_flow = (phase % 4 == 3);
      send_random_run(100);
      settle();
      steady_flow = 1'b0;
      phase++;
    end
  endtask

  initial begin : main
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_reset_values();
    test_directed_packets();
    test_register_extremes();
    test_output_backpressure();
    test_random_streams();
    settle();
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### files.f
+incdir+design
design/psinv_pkg.sv
design/psinv_rem.sv
design/packet_sequence_slice_inventory.sv
test/packet_sequence_slice_inventory_test.sv
